// ===== hw/rtl/satq_pkg.sv =====
// Shared types and constants for the summed-area table query block.
package satq_pkg;

	localparam int DIM_W     = 7;
	localparam int FIELD_W   = 6;
	localparam int VAL_W     = 16;
	localparam int SUM_W     = 32;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam int CRN_MAIN = 0;
	localparam int CRN_UP   = 1;
	localparam int CRN_LEFT = 2;
	localparam int CRN_DIAG = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_RANGE  = 2'd1,
		ST_NOT_LOADED = 2'd2
	} status_t;

	typedef struct packed {
		logic                    req_type;
		logic signed [VAL_W-1:0] cell_value;
		logic [FIELD_W-1:0]      top_row;
		logic [FIELD_W-1:0]      left_col;
		logic [FIELD_W-1:0]      bottom_row;
		logic [FIELD_W-1:0]      right_col;
	} req_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] rect_sum;
		status_t                 status;
	} resp_t;

	typedef struct packed {
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
	} pos_t;

	typedef struct packed {
		logic             is_query;
		status_t          status;
		logic [3:0]       use_mask;
		pos_t [3:0]       corner;
		logic [SUM_W-1:0] part_sum;
	} cmd_t;

endpackage

// ===== hw/rtl/satq_fifo.sv =====
// Small register queue used between the block's parts and at the result side.
module satq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== hw/rtl/satq_front.sv =====
// Front part: grid size registers, load position tracking and request classification.
module satq_front #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [satq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [satq_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               push,
	output logic                               full,
	input  satq_pkg::req_t                     req,
	output logic                               cmd_push,
	output satq_pkg::cmd_t                     cmd,
	input  logic                               cmd_full
);
	import satq_pkg::*;

	localparam int ROWS_RST = (64 > MAX_ROWS) ? MAX_ROWS : 64;
	localparam int COLS_RST = (64 > MAX_COLS) ? MAX_COLS : 64;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
		logic [DIM_W-1:0] res;
		if (v == '0) begin
			res = DIM_W'(1);
		end else if (int'(v) > maxv) begin
			res = DIM_W'(maxv);
		end else begin
			res = DIM_W'(v);
		end
		return res;
	endfunction

	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic [DIM_W-1:0] load_row_q;
	logic [DIM_W-1:0] load_col_q;
	logic [SUM_W-1:0] run_sum_q;
	logic             table_full_q;

	logic             accept;
	logic [DIM_W-1:0] row_base;
	logic [DIM_W-1:0] col_base;
	logic [SUM_W-1:0] sum_base;
	logic             off_grid;
	logic [DIM_W-1:0] row_eff;
	logic [DIM_W-1:0] col_eff;
	logic [SUM_W-1:0] sum_new;
	logic [DIM_W-1:0] row_next;
	logic [DIM_W-1:0] col_next;
	logic             row_wrap;
	logic             grid_done;
	logic [DIM_W-1:0] q_top;
	logic [DIM_W-1:0] q_left;
	logic [DIM_W-1:0] q_bot;
	logic [DIM_W-1:0] q_right;
	logic [DIM_W-1:0] q_top_m1;
	logic [DIM_W-1:0] q_left_m1;
	logic             bad_range;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign cmd_push = accept;

	// Load position: restart after a full table, keep inside the grid in use.
	assign row_base  = table_full_q ? '0 : load_row_q;
	assign col_base  = table_full_q ? '0 : load_col_q;
	assign sum_base  = table_full_q ? '0 : run_sum_q;
	assign off_grid  = (row_base >= rows_q) || (col_base >= cols_q);
	assign row_eff   = off_grid ? '0 : row_base;
	assign col_eff   = off_grid ? '0 : col_base;
	assign sum_new   = (off_grid ? '0 : sum_base)
		+ {{(SUM_W - VAL_W){req.cell_value[VAL_W-1]}}, req.cell_value};
	assign row_next  = row_eff + 1'b1;
	assign col_next  = col_eff + 1'b1;
	assign row_wrap  = (col_next >= cols_q);
	assign grid_done = row_wrap && (row_next >= rows_q);

	assign q_top     = DIM_W'(req.top_row);
	assign q_left    = DIM_W'(req.left_col);
	assign q_bot     = DIM_W'(req.bottom_row);
	assign q_right   = DIM_W'(req.right_col);
	assign q_top_m1  = (q_top != '0) ? q_top - 1'b1 : '0;
	assign q_left_m1 = (q_left != '0) ? q_left - 1'b1 : '0;
	assign bad_range = (q_top > q_bot) || (q_left > q_right)
		|| (q_bot >= rows_q) || (q_right >= cols_q);

	always_comb begin
		cmd = '0;
		if (req.req_type == REQ_LOAD) begin
			cmd.is_query               = 1'b0;
			cmd.status                 = ST_OK;
			cmd.use_mask[CRN_MAIN]     = 1'b1;
			cmd.use_mask[CRN_UP]       = (row_eff != '0);
			cmd.corner[CRN_MAIN].row   = row_eff;
			cmd.corner[CRN_MAIN].col   = col_eff;
			cmd.corner[CRN_UP].row     = (row_eff != '0) ? row_eff - 1'b1 : '0;
			cmd.corner[CRN_UP].col     = col_eff;
			cmd.part_sum               = sum_new;
		end else begin
			cmd.is_query = 1'b1;
			if (bad_range) begin
				cmd.status = ST_BAD_RANGE;
			end else if (!table_full_q) begin
				cmd.status = ST_NOT_LOADED;
			end else begin
				cmd.status = ST_OK;
			end
			cmd.use_mask[CRN_MAIN]   = 1'b1;
			cmd.use_mask[CRN_UP]     = (q_top != '0);
			cmd.use_mask[CRN_LEFT]   = (q_left != '0);
			cmd.use_mask[CRN_DIAG]   = (q_top != '0) && (q_left != '0);
			cmd.corner[CRN_MAIN].row = q_bot;
			cmd.corner[CRN_MAIN].col = q_right;
			cmd.corner[CRN_UP].row   = q_top_m1;
			cmd.corner[CRN_UP].col   = q_right;
			cmd.corner[CRN_LEFT].row = q_bot;
			cmd.corner[CRN_LEFT].col = q_left_m1;
			cmd.corner[CRN_DIAG].row = q_top_m1;
			cmd.corner[CRN_DIAG].col = q_left_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q       <= DIM_W'(ROWS_RST);
			cols_q       <= DIM_W'(COLS_RST);
			load_row_q   <= '0;
			load_col_q   <= '0;
			run_sum_q    <= '0;
			table_full_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROWS: rows_q <= clamp_dim(cfg_data, MAX_ROWS);
				REG_COLS: cols_q <= clamp_dim(cfg_data, MAX_COLS);
				default: ;
			endcase
			load_row_q   <= '0;
			load_col_q   <= '0;
			run_sum_q    <= '0;
			table_full_q <= 1'b0;
		end else if (accept && (req.req_type == REQ_LOAD)) begin
			if (row_wrap) begin
				load_col_q <= '0;
				run_sum_q  <= '0;
				load_row_q <= grid_done ? '0 : row_next;
			end else begin
				load_col_q <= col_next;
				run_sum_q  <= sum_new;
				load_row_q <= row_eff;
			end
			table_full_q <= grid_done;
		end
	end
endmodule

// ===== hw/rtl/satq_back.sv =====
// Back part: table memory, load write-back and four-corner query sequencing.
module satq_back #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_empty,
	input  satq_pkg::cmd_t  cmd,
	output logic            cmd_pop,
	input  logic            res_full,
	output logic            res_push,
	output satq_pkg::resp_t res
);
	import satq_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [5:0] {
		B_IDLE  = 6'b000001,
		B_LD_RD = 6'b000010,
		B_LD_WR = 6'b000100,
		B_QRY   = 6'b001000,
		B_ACC   = 6'b010000,
		B_PUSH  = 6'b100000
	} bstate_t;

	logic [SUM_W-1:0] mem [DEPTH];
	logic [SUM_W-1:0] rd_q;
	bstate_t          state_q;
	cmd_t             cmd_q;
	logic [1:0]       step_q;
	logic [SUM_W-1:0] acc_q;

	logic [1:0]       sel;
	pos_t             pos;
	logic [31:0]      addr_full;
	logic [AW-1:0]    mem_addr;
	logic             mem_we;
	logic             mem_re;
	logic [SUM_W-1:0] wdata;
	logic [1:0]       tidx;
	logic [SUM_W-1:0] term;
	logic             term_neg;
	logic [SUM_W-1:0] acc_next;

	always_comb begin
		unique case (state_q)
			B_LD_RD: sel = 2'(CRN_UP);
			B_QRY:   sel = step_q;
			default: sel = 2'(CRN_MAIN);
		endcase
	end

	assign pos       = cmd_q.corner[sel];
	assign addr_full = 32'(pos.row) * 32'(MAX_COLS) + 32'(pos.col);
	assign mem_addr  = addr_full[AW-1:0];
	assign mem_we    = (state_q == B_LD_WR);
	assign mem_re    = (state_q == B_LD_RD) || (state_q == B_QRY);
	assign wdata     = cmd_q.part_sum + (cmd_q.use_mask[CRN_UP] ? rd_q : '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= wdata;
		end else if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	assign tidx     = (state_q == B_ACC) ? 2'(CRN_DIAG) : step_q - 2'd1;
	assign term     = cmd_q.use_mask[tidx] ? rd_q : '0;
	assign term_neg = (tidx == 2'(CRN_UP)) || (tidx == 2'(CRN_LEFT));
	assign acc_next = term_neg ? acc_q - term : acc_q + term;

	assign cmd_pop       = (state_q == B_IDLE) && !cmd_empty;
	assign res_push      = (state_q == B_PUSH) && !res_full;
	assign res.rect_sum  = acc_q;
	assign res.status    = cmd_q.status;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
			acc_q   <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!cmd_empty) begin
						step_q <= '0;
						acc_q  <= '0;
						if (!cmd.is_query) begin
							state_q <= cmd.use_mask[CRN_UP] ? B_LD_RD : B_LD_WR;
						end else if (cmd.status == ST_OK) begin
							state_q <= B_QRY;
						end else begin
							state_q <= B_PUSH;
						end
					end
				end
				B_LD_RD: state_q <= B_LD_WR;
				B_LD_WR: state_q <= B_IDLE;
				B_QRY: begin
					if (step_q != '0) begin
						acc_q <= acc_next;
					end
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= B_ACC;
					end
				end
				B_ACC: begin
					acc_q   <= acc_next;
					state_q <= B_PUSH;
				end
				B_PUSH: begin
					if (!res_full) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/summed_area_table_query.sv =====
// Top level of the summed-area table query block.
//
// Requests enter through a queue-style port (push/full, req); a word is taken
// when push is high and full is low. A load word (req_type 0) adds the next
// grid value in row-major order and gives no result; a query word (req_type 1)
// gives one result word (rect_sum, status) on resp while empty is low, taken
// when pop is high. Grid size is set through cfg_wen/cfg_index/cfg_data; the user
// must write it only while the block is idle, which the block itself does not
// enforce, and a write restarts loading at the first cell. The front part
// classifies each word and tracks the load position, then places a command in a
// two-entry queue. The back part owns the single-port table memory and handles
// one command at a time: a load reads the cell above (except on the first row)
// and writes back, a valid query reads the four corners, then accumulates and
// hands off, and a query with a bad range or an incomplete table goes straight
// to hand-off.
// Reset clears the queues, the load position and the full flag and sets both
// grid dimensions to 64 (limited to the parameters); table contents are not
// cleared. When the receiver holds pop low, results collect in a two-entry
// output queue, then the back part waits and the front queue fills and raises full.
module summed_area_table_query #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [satq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [satq_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           push,
	output logic                           full,
	input  satq_pkg::req_t                 req,
	output logic                           empty,
	input  logic                           pop,
	output satq_pkg::resp_t                resp
);
	import satq_pkg::*;

	localparam int CMD_W  = $bits(cmd_t);
	localparam int RESP_W = $bits(resp_t);

	logic  cmd_push;
	logic  cmd_full;
	logic  cmd_empty;
	logic  cmd_pop;
	cmd_t  cmd_in;
	cmd_t  cmd_out;
	logic  res_push;
	logic  res_full;
	resp_t res_in;

	satq_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.req      (req),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	satq_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_in),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_out),
		.empty  (cmd_empty)
	);

	satq_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	satq_fifo #(
		.WIDTH(RESP_W),
		.DEPTH(2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(resp),
		.empty  (empty)
	);
endmodule

// ===== hw/rtl/satq_checker.sv =====
// Port-level checks for the summed-area table query block, bound to the top level.
module satq_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            push,
	input logic            full,
	input logic            empty,
	input logic            pop,
	input satq_pkg::resp_t resp
);
	import satq_pkg::*;

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result queue not empty after reset");

	a_reset_not_full: assert property (@(posedge clk) !arst_n |=> !full)
		else $error("request side full after reset");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (resp.status != ST_OK)) |-> (resp.rect_sum == '0))
		else $error("error result carries a nonzero sum");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(resp)))
		else $error("waiting result word changed or vanished");
endmodule

bind summed_area_table_query satq_checker u_satq_checker (.*);

// ===== sim/tb_summed_area_table_query.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for summed_area_table_query: grid loads, rectangle queries, checks.
module tb_summed_area_table_query;
	import satq_pkg::*;

	localparam int GRID_ROWS      = 64;
	localparam int GRID_COLS      = 64;
	localparam int TIMEOUT_CYCLES = 600000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int RAND_ITEMS     = 1500;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 push      = 1'b0;
	logic                 full;
	req_t                 req       = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	resp_t                resp;

	summed_area_table_query #(
		.MAX_ROWS(GRID_ROWS),
		.MAX_COLS(GRID_COLS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.req      (req),
		.empty    (empty),
		.pop      (pop),
		.resp     (resp)
	);

	always #5 clk = ~clk;

	logic [SUM_W-1:0] sat_cell [GRID_ROWS][GRID_COLS];
	int               sat_rows = GRID_ROWS;
	int               sat_cols = GRID_COLS;
	int               fill_row = 0;
	int               fill_col = 0;
	logic [SUM_W-1:0] fill_run = '0;
	bit               sat_full = 1'b0;

	req_t  words_pending [$];
	resp_t answers_due [$];

	int   src_pct       = 0;
	int   dst_pct       = 0;
	logic hold_kick     = 1'b0;
	int   hold_left     = 0;
	int   mismatches    = 0;
	int   words_taken   = 0;
	int   words_queued  = 0;
	int   answers_seen  = 0;
	int   cfg_writes    = 0;
	int   cycle_count   = 0;
	int   status_seen [3] = '{0, 0, 0};

	function automatic void restart_fill();
		fill_row = 0;
		fill_col = 0;
		fill_run = '0;
		sat_full = 1'b0;
	endfunction

	function automatic void sat_step(req_t w);
		int               t, l, b, r;
		logic [SUM_W-1:0] above, corner_up, corner_left, corner_diag;
		resp_t            ans;
		if (w.req_type == REQ_LOAD) begin
			if (sat_full)
				restart_fill();
			if (fill_row >= sat_rows || fill_col >= sat_cols) begin
				fill_row = 0;
				fill_col = 0;
				fill_run = '0;
			end
			fill_run = fill_run + {{(SUM_W-VAL_W){w.cell_value[VAL_W-1]}}, w.cell_value};
			above = (fill_row > 0) ? sat_cell[fill_row-1][fill_col] : '0;
			sat_cell[fill_row][fill_col] = fill_run + above;
			fill_col++;
			if (fill_col >= sat_cols) begin
				fill_col = 0;
				fill_run = '0;
				fill_row++;
				if (fill_row >= sat_rows) begin
					fill_row = 0;
					sat_full = 1'b1;
				end
			end
		end else begin
			t = w.top_row;
			l = w.left_col;
			b = w.bottom_row;
			r = w.right_col;
			ans.rect_sum = '0;
			if (t > b || l > r || b >= sat_rows || r >= sat_cols) begin
				ans.status = ST_BAD_RANGE;
			end else if (!sat_full) begin
				ans.status = ST_NOT_LOADED;
			end else begin
				ans.status = ST_OK;
				corner_up   = (t > 0) ? sat_cell[t-1][r] : '0;
				corner_left = (l > 0) ? sat_cell[b][l-1] : '0;
				corner_diag = (t > 0 && l > 0) ? sat_cell[t-1][l-1] : '0;
				ans.rect_sum = sat_cell[b][r] - corner_up - corner_left + corner_diag;
			end
			answers_due.push_back(ans);
		end
	endfunction

	always @(posedge clk) begin : drive_words
		if (arst_n) begin
			if (push && !full) begin
				sat_step(req);
				words_taken++;
			end
			if (!push || !full) begin
				if (words_pending.size() != 0 && $urandom_range(99) >= src_pct) begin
					req  <= words_pending.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_answers
		resp_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				answers_seen++;
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: sum %0d status %0d",
							resp.rect_sum, resp.status);
				end else begin
					want = answers_due.pop_front();
					status_seen[want.status]++;
					if (resp.rect_sum !== want.rect_sum || resp.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: sum %0d status %0d, expected sum %0d status %0d",
								answers_seen, resp.rect_sum, resp.status,
								want.rect_sum, want.status);
					end
				end
			end
			pop <= (hold_left == 0) && ($urandom_range(99) >= dst_pct);
		end
	end

	always @(posedge clk) begin : receiver_hold
		if (hold_kick)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, answers_due.size());
			$display("tb_summed_area_table_query NOT OK");
			$finish;
		end
	end

	function automatic req_t rand_word(logic kind);
		req_t w;
		w.req_type   = kind;
		w.cell_value = VAL_W'($urandom);
		w.top_row    = FIELD_W'($urandom);
		w.left_col   = FIELD_W'($urandom);
		w.bottom_row = FIELD_W'($urandom);
		w.right_col  = FIELD_W'($urandom);
		return w;
	endfunction

	function automatic req_t load_word(logic [VAL_W-1:0] v);
		req_t w;
		w = rand_word(REQ_LOAD);
		w.cell_value = v;
		return w;
	endfunction

	function automatic req_t query_word(int t, int l, int b, int r);
		req_t w;
		w = rand_word(REQ_QUERY);
		w.top_row    = FIELD_W'(t);
		w.left_col   = FIELD_W'(l);
		w.bottom_row = FIELD_W'(b);
		w.right_col  = FIELD_W'(r);
		return w;
	endfunction

	function automatic void offer(req_t w);
		words_pending.push_back(w);
		words_queued++;
	endfunction

	function automatic logic [VAL_W-1:0] grid_value();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic void valid_query();
		int t, l;
		t = $urandom_range(sat_rows - 1, 0);
		l = $urandom_range(sat_cols - 1, 0);
		offer(query_word(t, l, $urandom_range(sat_rows - 1, t), $urandom_range(sat_cols - 1, l)));
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(9))
			0: return 0;
			1: return $urandom_range(16, 9);
			default: return $urandom_range(8, 1);
		endcase
	endfunction

	task automatic write_reg(cfg_reg_t idx, int val);
		int dim;
		dim = (val == 0) ? 1 : val;
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_ROWS)
			sat_rows = (dim > GRID_ROWS) ? GRID_ROWS : dim;
		else
			sat_cols = (dim > GRID_COLS) ? GRID_COLS : dim;
		restart_fill();
		cfg_writes++;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (words_pending.size() != 0 || push || answers_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic grid_session(int rows_w, int cols_w, bit squeeze);
		int cells, reps, n, k;
		if ($urandom_range(1)) begin
			write_reg(REG_ROWS, rows_w);
			write_reg(REG_COLS, cols_w);
		end else begin
			write_reg(REG_COLS, cols_w);
			write_reg(REG_ROWS, rows_w);
		end
		@(negedge clk);
		cells = sat_rows * sat_cols;
		reps  = (cells > 256) ? 1 : $urandom_range(2, 1);
		repeat (reps) begin
			for (k = 0; k < cells; k++) begin
				if ($urandom_range(24) == 0)
					offer(rand_word(REQ_QUERY));
				offer(load_word(grid_value()));
			end
			offer(query_word(0, 0, sat_rows - 1, sat_cols - 1));
			offer(query_word(sat_rows - 1, sat_cols - 1, sat_rows - 1, sat_cols - 1));
			n = $urandom_range(16, 3);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(6) == 0)
					offer(rand_word(REQ_QUERY));
				else
					valid_query();
			end
		end
		// restart a full table with a short partial load
		if ($urandom_range(4) == 0) begin
			n = $urandom_range((cells > 20) ? 20 : cells - 1, 1);
			for (k = 0; k < n; k++)
				offer(load_word(grid_value()));
			repeat ($urandom_range(3, 1)) valid_query();
			offer(rand_word(REQ_QUERY));
		end
		if (squeeze) begin
			@(posedge clk);
			hold_kick <= 1'b1;
			@(posedge clk);
			hold_kick <= 1'b0;
		end
		drain();
	endtask

	initial begin : stimulus
		int stage, random_start;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_pct <= 8;
		dst_pct <= 56;
		@(negedge clk);

		offer(query_word(0, 0, 63, 63));
		offer(query_word(5, 0, 4, 0));
		offer(query_word(0, 9, 0, 8));
		offer(load_word(16'h7fff));
		offer(load_word(16'h8000));
		offer(query_word(0, 0, 0, 1));
		drain();

		write_reg(REG_ROWS, 0);
		write_reg(REG_COLS, 3);
		@(negedge clk);
		offer(load_word(16'h7fff));
		offer(load_word(16'h8000));
		offer(load_word(16'hffff));
		offer(query_word(0, 0, 0, 2));
		offer(query_word(0, 1, 0, 1));
		offer(query_word(0, 2, 0, 2));
		offer(query_word(0, 0, 1, 0));
		offer(query_word(0, 3, 0, 3));
		offer(query_word(63, 63, 63, 63));
		offer(load_word(16'h0005));
		offer(query_word(0, 0, 0, 0));
		drain();

		grid_session(127, 1, 1'b0);
		grid_session(1, 100, 1'b0);

		random_start = words_queued;
		for (stage = 0; stage < 3; stage++) begin
			@(posedge clk);
			src_pct <= (stage == 0) ? 8 : (stage == 1) ? 56 : 0;
			dst_pct <= (stage == 0) ? 56 : (stage == 1) ? 8 : 0;
			if (stage == 2)
				grid_session(4, 4, 1'b1);
			while (words_queued - random_start < (stage + 1) * RAND_ITEMS / 3)
				grid_session(pick_dim(), pick_dim(), 1'b0);
		end
		drain();

		$display("checked %0d results from %0d accepted words: %0d ok, %0d bad range, %0d not loaded",
			answers_seen, words_taken, status_seen[ST_OK], status_seen[ST_BAD_RANGE],
			status_seen[ST_NOT_LOADED]);
		$display("%0d register writes, grids from 1x1 up to 64x1 and 1x64, one %0d-cycle hold-off",
			cfg_writes, HOLD_CYCLES);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("tb_summed_area_table_query OK");
		else
			$display("tb_summed_area_table_query NOT OK");
		$finish;
	end

endmodule
